>>> hdl/tsvp_pkg.sv
// Package for the Taylor-series state-vector propagator.
// Holds the state encoding, register indexes, field widths and saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package tsvp_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int SEG_W      = 16;
    localparam int QCNT_W     = 3;
    localparam int WIDE_W     = 68;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_EVOLVE_TIME   = 3'd0;
    localparam cfg_index_t REG_STEP_SIZE     = 3'd1;
    localparam cfg_index_t REG_TOLERANCE     = 3'd2;
    localparam cfg_index_t REG_SEGMENT_INDEX = 3'd3;
    localparam cfg_index_t REG_QUBIT_COUNT   = 3'd4;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SETUP,
        ST_TERM,
        ST_NB,
        ST_ALU,
        ST_DIV,
        ST_POST,
        ST_NEXT,
        ST_OUT_RD,
        ST_OUT_SHOW
    } state_t;

    // Clamps a wide signed value into the 32-bit signed range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi_lim;
        logic signed [WIDE_W-1:0] lo_lim;
        hi_lim = WIDE_W'(32'sh7FFF_FFFF);
        lo_lim = WIDE_W'(32'sh8000_0000);
        if (v > hi_lim)
            return 32'sh7FFF_FFFF;
        else if (v < lo_lim)
            return 32'sh8000_0000;
        else
            return v[DATA_W-1:0];
    endfunction

endpackage

>>> hdl/tsvp_if.sv
// Channel interfaces of the propagator: input items, result items and register writes.
// Depends on nothing; widths follow the field list of the block.
`timescale 1ns / 1ps

interface tsvp_item_if;
    logic        valid;
    logic        ready;
    logic [31:0] diag_energy;
    logic [31:0] amp_real;
    logic [31:0] amp_imag;

    modport source (output valid, output diag_energy, output amp_real, output amp_imag,
                    input ready);
    modport sink   (input valid, input diag_energy, input amp_real, input amp_imag,
                    output ready);
endinterface

interface tsvp_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_real;
    logic [31:0] out_imag;
    logic        last_out;
    logic        converged;

    modport source (output valid, output out_real, output out_imag, output last_out,
                    output converged, input ready);
    modport sink   (input valid, input out_real, input out_imag, input last_out,
                    input converged, output ready);
endinterface

interface tsvp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [30:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/taylor_state_vector_propagator.sv
// Top level of the Taylor-series state-vector propagator.
// Depends on tsvp_pkg, the channel interfaces in tsvp_if and tsvp_divider.
// Each input item writes one amplitude and its energy; after 2^q items the vector is
// propagated and the q-qubit results are streamed out, each read (ST_OUT_RD) and then
// shown (ST_OUT_SHOW) until it is taken. The time per correction term is set by the
// one-read-per-cycle neighbour fetch from the term memory, the shared 32x32
// multiplier and the bit-serial divide by the term number.
`timescale 1ns / 1ps

module taylor_state_vector_propagator #(
    parameter int MAX_QUBITS = 6,
    parameter int MAX_TERMS  = 64,
    parameter int FRAC_BITS  = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    tsvp_item_if.sink     items,
    tsvp_result_if.source results,
    tsvp_cfg_if.sink      cfg
);
    import tsvp_pkg::*;

    localparam int AW    = MAX_QUBITS;
    localparam int DEPTH = 1 << AW;
    localparam int NW    = $clog2(MAX_TERMS + 1);
    localparam int CW    = $clog2(MAX_QUBITS + 2);
    localparam int ACC_W = DATA_W + 3;

    // Configuration.
    logic [CFG_DATA_W-1:0] evolve_time_reg;
    logic [CFG_DATA_W-1:0] step_size_reg;
    logic [CFG_DATA_W-1:0] tolerance_reg;
    logic [SEG_W-1:0]      segment_reg;
    logic [QCNT_W-1:0]     qubit_reg;

    // Control.
    state_t           state_reg, state_next;
    logic [3:0]       step_reg;
    logic [AW-1:0]    load_count_reg;
    logic [AW-1:0]    k_reg;
    logic [NW-1:0]    n_reg;
    logic [CW-1:0]    nb_cnt_reg;
    logic             rd_pend_reg;
    logic             rd_own_reg;
    logic             done_reg;

    // Datapath.
    logic signed [DATA_W-1:0] d_reg, omd_reg, stepn_reg;
    logic [61:0]              tol2_reg;
    logic [63:0]              energy_reg;
    logic [63:0]              sqs_reg;
    logic [62:0]              sqr_reg;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;
    logic signed [DATA_W-1:0] tr_reg, ti_reg, hr_reg, hi_reg, fr_reg, fi_reg;
    logic signed [DATA_W-1:0] ar_reg, br_reg, ai_reg, bi_reg, yr_reg, yi_reg, ur_reg;
    logic signed [DATA_W-1:0] pr_reg, pi_reg, cr_reg, ci_reg;
    logic signed [63:0]       prod_reg;

    // Memories; each complex entry packs real above imaginary, the energy store holds one value.
    logic [DATA_W-1:0]   energy_mem [DEPTH];
    logic [2*DATA_W-1:0] sum_mem    [DEPTH];
    logic [2*DATA_W-1:0] term_mem   [2*DEPTH];
    logic [2*DATA_W-1:0] mp_mem     [DEPTH];
    logic [2*DATA_W-1:0] dp_mem     [DEPTH];
    logic [DATA_W-1:0]   energy_rd_reg;
    logic [2*DATA_W-1:0] sum_rd_reg, term_rd_reg, mp_rd_reg, dp_rd_reg;

    logic                 in_acc, out_acc, cfg_acc;
    logic [QCNT_W-1:0]    qa;
    logic [AW:0]          len_full;
    logic [AW-1:0]        len_m1;
    logic                 k_last;
    logic                 first_term;
    logic                 done_eval;
    logic                 finish;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [63:0]   rnd;
    logic signed [DATA_W-1:0] mulq_res;
    logic [AW:0]          term_raddr;
    logic                 post_we;
    logic [AW-1:0]        sum_waddr;
    logic                 div_start;
    logic                 div_done_r, div_done_i;
    logic signed [DATA_W-1:0] q_r, q_i;
    logic signed [DATA_W-1:0] t_op, stp_op;
    logic [AW-1:0]        nb_mask;
    logic signed [DATA_W-1:0] extra_r, extra_i;
    logic [64:0]          esum;
    logic [SEG_W-1:0]     seg_m1;

    assign in_acc  = items.valid && items.ready;
    assign out_acc = results.valid && results.ready;
    assign cfg_acc = cfg.valid && cfg.ready;

    always_comb
    begin
        if (qubit_reg == '0)
            qa = QCNT_W'(1);
        else if (qubit_reg > QCNT_W'(MAX_QUBITS))
            qa = QCNT_W'(MAX_QUBITS);
        else
            qa = qubit_reg;
    end

    assign len_full   = (AW + 1)'(1) << qa;
    assign len_m1     = AW'(len_full - 1'b1);
    assign k_last     = k_reg == len_m1;
    assign first_term = n_reg == NW'(1);
    assign done_eval  = done_reg || (!first_term && (energy_reg <= {2'b00, tol2_reg}));
    assign finish     = done_eval || (n_reg == NW'(MAX_TERMS));
    assign t_op       = {1'b0, evolve_time_reg};
    assign stp_op     = {1'b0, step_size_reg};
    assign seg_m1     = (segment_reg == '0) ? '0 : segment_reg - 1'b1;
    assign nb_mask    = AW'(1) << nb_cnt_reg;

    // The previous-term differences only enter from the second term on.
    assign extra_r = first_term ? '0 : $signed(dp_rd_reg[2*DATA_W-1:DATA_W]);
    assign extra_i = first_term ? '0 : $signed(dp_rd_reg[DATA_W-1:0]);

    // Rounded Q-format product of the previous cycle's multiplication.
    assign rnd      = prod_reg + (64'sd1 <<< (FRAC_BITS - 1));
    assign mulq_res = sat32(WIDE_W'(rnd >>> FRAC_BITS));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
                if (in_acc && load_count_reg == len_m1)
                    state_next = ST_SETUP;
            ST_SETUP:
                if (step_reg == 4'd2)
                    state_next = ST_TERM;
            ST_TERM:
                if (first_term || step_reg == 4'd1)
                    state_next = ST_NB;
            ST_NB:
                if (rd_pend_reg && rd_own_reg)
                    state_next = ST_ALU;
            ST_ALU:
                if (step_reg == 4'd9)
                    state_next = first_term ? ST_POST : ST_DIV;
            ST_DIV:
                if (div_done_r)
                    state_next = ST_POST;
            ST_POST:
                if (step_reg == 4'd5)
                    state_next = ST_NEXT;
            ST_NEXT:
                if (!k_last)
                    state_next = ST_NB;
                else if (finish)
                    state_next = ST_OUT_RD;
                else
                    state_next = ST_TERM;
            ST_OUT_RD:
                state_next = ST_OUT_SHOW;
            ST_OUT_SHOW:
                if (out_acc)
                    state_next = k_last ? ST_LOAD : ST_OUT_RD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    // Outputs of the sequencer: multiplier operands, memory controls, divider start.
    always_comb
    begin
        mul_a      = '0;
        mul_b      = '0;
        post_we    = 1'b0;
        div_start  = 1'b0;
        term_raddr = {~n_reg[0], (nb_cnt_reg == CW'(qa)) ? k_reg : (k_reg ^ nb_mask)};
        sum_waddr  = (state_reg == ST_LOAD) ? load_count_reg : k_reg;
        case (state_reg)
            ST_SETUP:
                if (step_reg == 4'd0)
                begin
                    mul_a = {16'b0, seg_m1};
                    mul_b = stp_op;
                end
                else
                begin
                    mul_a = {1'b0, tolerance_reg};
                    mul_b = {1'b0, tolerance_reg};
                end
            ST_TERM:
            begin
                mul_a = stepn_reg;
                mul_b = stp_op;
            end
            ST_ALU:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        mul_a = $signed(energy_rd_reg);
                        mul_b = tr_reg;
                    end
                    4'd1:
                    begin
                        mul_a = $signed(energy_rd_reg);
                        mul_b = ti_reg;
                    end
                    4'd2:
                    begin
                        mul_a = omd_reg;
                        mul_b = hr_reg;
                    end
                    4'd3:
                    begin
                        mul_a = d_reg;
                        mul_b = fr_reg;
                    end
                    4'd4:
                    begin
                        mul_a = omd_reg;
                        mul_b = hi_reg;
                    end
                    4'd5:
                    begin
                        mul_a = d_reg;
                        mul_b = fi_reg;
                    end
                    4'd6:
                    begin
                        mul_a = t_op;
                        mul_b = yr_reg;
                    end
                    4'd8:
                    begin
                        mul_a = t_op;
                        mul_b = yi_reg;
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
                div_start = (step_reg == 4'd9) && !first_term;
            end
            ST_POST:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        mul_a = pr_reg;
                        mul_b = stepn_reg;
                    end
                    4'd1:
                    begin
                        mul_a = pi_reg;
                        mul_b = stepn_reg;
                    end
                    4'd2:
                    begin
                        mul_a = cr_reg;
                        mul_b = cr_reg;
                    end
                    4'd3:
                    begin
                        mul_a = ci_reg;
                        mul_b = ci_reg;
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
                post_we = step_reg == 4'd4;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            step_reg        <= '0;
            load_count_reg  <= '0;
            k_reg           <= '0;
            n_reg           <= NW'(1);
            nb_cnt_reg      <= '0;
            rd_pend_reg     <= 1'b0;
            rd_own_reg      <= 1'b0;
            done_reg        <= 1'b0;
            evolve_time_reg <= '0;
            step_size_reg   <= '0;
            tolerance_reg   <= '0;
            segment_reg     <= SEG_W'(1);
            qubit_reg       <= QCNT_W'(6);
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= (state_next != state_reg) ? '0 : step_reg + 1'b1;

            if (cfg_acc)
            begin
                case (cfg.index)
                    REG_EVOLVE_TIME:   evolve_time_reg <= cfg.data;
                    REG_STEP_SIZE:     step_size_reg   <= cfg.data;
                    REG_TOLERANCE:     tolerance_reg   <= cfg.data;
                    REG_SEGMENT_INDEX: segment_reg     <= cfg.data[SEG_W-1:0];
                    REG_QUBIT_COUNT:   qubit_reg       <= cfg.data[QCNT_W-1:0];
                    default:           ;
                endcase
            end

            if (cfg_acc && cfg.index == REG_QUBIT_COUNT)
                load_count_reg <= '0;
            else if (in_acc)
                load_count_reg <= (load_count_reg == len_m1) ? '0 : load_count_reg + 1'b1;

            if (state_reg == ST_NB && nb_cnt_reg <= CW'(qa))
                nb_cnt_reg <= nb_cnt_reg + 1'b1;
            else if (state_reg != ST_NB)
                nb_cnt_reg <= '0;
            rd_pend_reg <= (state_reg == ST_NB) && (nb_cnt_reg <= CW'(qa));
            rd_own_reg  <= nb_cnt_reg == CW'(qa);

            case (state_reg)
                ST_SETUP:
                    if (step_reg == 4'd2)
                    begin
                        n_reg    <= NW'(1);
                        done_reg <= 32'(tolerance_reg) >= (32'd1 << FRAC_BITS);
                    end
                ST_TERM:
                    k_reg <= '0;
                ST_NEXT:
                begin
                    k_reg <= k_last ? '0 : k_reg + 1'b1;
                    if (k_last)
                    begin
                        done_reg <= done_eval;
                        if (!finish)
                            n_reg <= n_reg + 1'b1;
                    end
                end
                ST_OUT_SHOW:
                    if (out_acc)
                        k_reg <= k_last ? '0 : k_reg + 1'b1;
                default:
                    ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_SETUP:
            begin
                if (step_reg == 4'd1)
                    d_reg <= sat32(WIDE_W'(prod_reg));
                if (step_reg == 4'd2)
                begin
                    tol2_reg  <= prod_reg[61:0];
                    omd_reg   <= sat32((WIDE_W'(1) <<< FRAC_BITS) - WIDE_W'(d_reg));
                    stepn_reg <= stp_op;
                end
            end
            ST_TERM:
            begin
                energy_reg <= '0;
                acc_re_reg <= '0;
                acc_im_reg <= '0;
                if (step_reg == 4'd1)
                    stepn_reg <= mulq_res;
            end
            ST_NB:
                if (rd_pend_reg)
                begin
                    if (rd_own_reg)
                    begin
                        tr_reg <= $signed(term_rd_reg[2*DATA_W-1:DATA_W]);
                        ti_reg <= $signed(term_rd_reg[DATA_W-1:0]);
                        hr_reg <= sat32(WIDE_W'(acc_re_reg));
                        hi_reg <= sat32(WIDE_W'(acc_im_reg));
                    end
                    else
                    begin
                        acc_re_reg <= acc_re_reg
                            - ACC_W'($signed(term_rd_reg[2*DATA_W-1:DATA_W]));
                        acc_im_reg <= acc_im_reg - ACC_W'($signed(term_rd_reg[DATA_W-1:0]));
                    end
                end
            ST_ALU:
                case (step_reg)
                    4'd1: fr_reg <= mulq_res;
                    4'd2: fi_reg <= mulq_res;
                    4'd3: ar_reg <= mulq_res;
                    4'd4: br_reg <= mulq_res;
                    4'd5:
                    begin
                        ai_reg <= mulq_res;
                        yr_reg <= sat32(WIDE_W'(ar_reg) + WIDE_W'(br_reg) + WIDE_W'(extra_r)
                                        - (first_term ? WIDE_W'(0)
                                           : WIDE_W'($signed(mp_rd_reg[2*DATA_W-1:DATA_W]))));
                    end
                    4'd6: bi_reg <= mulq_res;
                    4'd7:
                    begin
                        ur_reg <= mulq_res;
                        yi_reg <= sat32(WIDE_W'(ai_reg) + WIDE_W'(bi_reg) + WIDE_W'(extra_i)
                                        - (first_term ? WIDE_W'(0)
                                           : WIDE_W'($signed(mp_rd_reg[DATA_W-1:0]))));
                    end
                    4'd9:
                        if (first_term)
                        begin
                            pr_reg <= mulq_res;
                            pi_reg <= sat32(-WIDE_W'(ur_reg));
                        end
                    default: ;
                endcase
            ST_DIV:
                if (div_done_r)
                begin
                    pr_reg <= q_i;
                    pi_reg <= -q_r;
                end
            ST_POST:
                case (step_reg)
                    4'd1: cr_reg  <= mulq_res;
                    4'd2: ci_reg  <= mulq_res;
                    4'd3: sqr_reg <= prod_reg[62:0];
                    4'd4: sqs_reg <= {1'b0, sqr_reg} + {1'b0, prod_reg[62:0]};
                    4'd5: energy_reg <= esum[64] ? '1 : esum[63:0];
                    default: ;
                endcase
            ST_NEXT:
            begin
                acc_re_reg <= '0;
                acc_im_reg <= '0;
            end
            default: ;
        endcase
    end

    assign esum = {1'b0, energy_reg} + {1'b0, sqs_reg};

    // Energy store: written while loading, read at the current index.
    always_ff @(posedge clk)
    begin
        if (in_acc)
            energy_mem[load_count_reg] <= items.diag_energy;
        energy_rd_reg <= energy_mem[k_reg];
    end

    // Running sum: loaded with the input vector, accumulated per term.
    always_ff @(posedge clk)
    begin
        if (in_acc)
            sum_mem[sum_waddr] <= {items.amp_real, items.amp_imag};
        else if (post_we)
            sum_mem[sum_waddr] <= {sat32(WIDE_W'($signed(sum_rd_reg[2*DATA_W-1:DATA_W]))
                                         + WIDE_W'(cr_reg)),
                                   sat32(WIDE_W'($signed(sum_rd_reg[DATA_W-1:0]))
                                         + WIDE_W'(ci_reg))};
        sum_rd_reg <= sum_mem[k_reg];
    end

    // Term store has two banks so that a term is read whole while the next is written.
    always_ff @(posedge clk)
    begin
        if (in_acc)
            term_mem[{1'b0, load_count_reg}] <= {items.amp_real, items.amp_imag};
        else if (post_we)
            term_mem[{n_reg[0], k_reg}] <= {pr_reg, pi_reg};
        term_rd_reg <= term_mem[term_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (post_we)
        begin
            mp_mem[k_reg] <= {hr_reg, hi_reg};
            dp_mem[k_reg] <= {fr_reg, fi_reg};
        end
        mp_rd_reg <= mp_mem[k_reg];
        dp_rd_reg <= dp_mem[k_reg];
    end

    tsvp_divider #(
        .DIV_W (NW)
    ) u_div_r (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ur_reg),
        .divisor  (n_reg),
        .done     (div_done_r),
        .quotient (q_r)
    );

    tsvp_divider #(
        .DIV_W (NW)
    ) u_div_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mulq_res),
        .divisor  (n_reg),
        .done     (div_done_i),
        .quotient (q_i)
    );

    assign items.ready       = state_reg == ST_LOAD;
    assign cfg.ready         = 1'b1;
    assign results.valid     = state_reg == ST_OUT_SHOW;
    assign results.out_real  = sum_rd_reg[2*DATA_W-1:DATA_W];
    assign results.out_imag  = sum_rd_reg[DATA_W-1:0];
    assign results.last_out  = k_last;
    assign results.converged = done_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(items.ready && results.valid))
        else $error("input and result channels active together");

    a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
        div_done_r == div_done_i)
        else $error("divider lanes out of step");

    a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= len_m1)
        else $error("load counter beyond vector length");

    a_term_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NEXT && k_last && n_reg == NW'(MAX_TERMS)) |=>
            state_reg == ST_OUT_RD)
        else $error("term count passed the cap");

endmodule

>>> hdl/tsvp_divider.sv
// Bit-serial signed divider: quotient truncated toward zero, one bit per cycle.
// Uses tsvp_pkg for the data width.
`timescale 1ns / 1ps

module tsvp_divider #(
    parameter int DIV_W = 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [31:0]       dividend,
    input  logic [DIV_W-1:0]         divisor,
    output logic                     done,
    output logic signed [31:0]       quotient
);
    import tsvp_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                neg_reg;
    logic [DATA_W-1:0]   quo_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [DIV_W-1:0]    den_reg;
    logic [DIV_W:0]      shifted;
    logic                fits;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[DATA_W-1];
            quo_reg <= dividend[DATA_W-1] ? 32'(-dividend) : dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DIV_W'(shifted - {1'b0, den_reg});
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DIV_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule
